@@ src/pwm_timer_setting_calculator_macros.svh @@
// Assertion helpers for the RTL
`ifndef PWM_TIMER_SETTING_CALCULATOR_MACROS_SVH
`define PWM_TIMER_SETTING_CALCULATOR_MACROS_SVH

// same-cycle implication
`define PTSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptsc assertion failed");

// next-cycle implication
`define PTSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptsc assertion failed");

`endif

@@ src/ptsc_pkg.sv @@
package ptsc_pkg;

	typedef enum logic [3:0] {
		CMD_ENABLE        = 4'd0,
		CMD_DISABLE       = 4'd1,
		CMD_GET_FREQ      = 4'd2,
		CMD_SET_FREQ      = 4'd3,
		CMD_GET_DUTY      = 4'd4,
		CMD_SET_DUTY      = 4'd5,
		CMD_GET_RAW       = 4'd6,
		CMD_SET_RAW       = 4'd7,
		CMD_SET_FREQ_DUTY = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAIT_PRE,
		ST_WAIT_PER,
		ST_WAIT_RAW,
		ST_SCAN,
		ST_EMIT
	} state_t;

	localparam logic REG_TIMER_CLOCK  = 1'b0;
	localparam logic REG_CHANNEL_MASK = 1'b1;

	localparam logic [29:0] TIMER_CLOCK_RESET = 30'd72000000;
	localparam logic [3:0]  CHANNEL_MASK_RESET = 4'd15;

	localparam logic [31:0] FREQ_LOW = 32'd600;
	localparam logic [31:0] FREQ_MID = 32'd1100;
	localparam logic [13:0] PRESC_LOW = 14'd9999;
	localparam logic [13:0] PRESC_MID = 14'd1;
	localparam logic [16:0] DUTY_ONE = 17'h10000;

	localparam logic [5:0] STEPS_32 = 6'd32;
	localparam logic [5:0] STEPS_48 = 6'd48;

	typedef struct packed {
		logic        start;
		logic [47:0] dividend;
		logic [31:0] divisor;
		logic [5:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic [47:0] quotient;
	} div_rsp_t;

endpackage

@@ src/ptsc_div.sv @@
module ptsc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ptsc_pkg::div_req_t req,
	output ptsc_pkg::div_rsp_t rsp
);
	import ptsc_pkg::*;

	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] divisor_q;
	logic [32:0] trial;
	logic [33:0] diff;
	logic        ge;

	// restoring division, one quotient bit a cycle, MSB first
	assign trial = {rem_q, quo_q[47]};
	assign diff  = {1'b0, trial} - {2'b0, divisor_q};
	assign ge    = !diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.steps;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (cnt_q != 6'd0) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[46:0], ge};
		end
	end

	assign rsp.busy     = (cnt_q != 6'd0);
	assign rsp.quotient = quo_q;

endmodule

@@ src/pwm_timer_setting_calculator.sv @@
// Enable, disable and get commands and rejections emit their result without using the divider.
// set_duty computes one channel's compare; set_raw runs a 48-step division on the shared divider.
// set_freq / set_freq_duty run two 32-step divisions and then scan the channels, emitting a result
// for each used one; results follow in ascending channel order.
// Throughput: one command at a time, the next input transfer once the last result is registered.
// Reset (arst_n low): all timer and channel state zero, clock 72000000 Hz, channel mask 15.
module pwm_timer_setting_calculator #(
	parameter int CHANNELS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [29:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,  // channel, freq_hz, duty_q16, compare_raw
	input  logic [3:0]   s_tuser,  // command
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,  // read_value, prescaler_out, period_out, channel_out,
	                               // compare_out, enabled
	output logic [1:0]   m_tuser,  // status, compare_write
	output logic         m_tlast
);
	import ptsc_pkg::*;

	`include "pwm_timer_setting_calculator_macros.svh"

	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [16:0] CH_LIM = (17'd1 << CHANNELS) - 17'd1;

	typedef enum logic [2:0] {ACT_EMIT, ACT_ERR, ACT_MUL, ACT_RAW, ACT_FREQ} act_t;

	state_t state_q, state_d;
	act_t   act;

	logic [29:0] clk_hz_q;
	logic [3:0]  mask_q;
	logic [13:0] presc_q;
	logic [31:0] period_q;
	logic [31:0] freq_q;
	logic [16:0] duty_q [CHANNELS];
	logic [31:0] cmp_q [CHANNELS];
	logic        en_q;

	logic [3:0]  cmd_in_q;
	logic [3:0]  ch_in_q;
	logic [31:0] f_in_q;
	logic [16:0] duty_in_q;
	logic [31:0] raw_in_q;

	logic [CHW-1:0] scan_q;
	logic           loop_q;

	logic        res_status_q;
	logic [31:0] res_read_q;
	logic [3:0]  res_ch_q;
	logic [31:0] res_cmp_q;
	logic        res_wr_q;
	logic        res_last_q;

	logic         out_valid_q;
	logic [119:0] out_data_q;
	logic [1:0]   out_user_q;
	logic         out_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [15:0]    used16;
	logic [CHW-1:0] idx;
	logic [CHW-1:0] rd_idx;
	logic           ch_ok;
	logic           scan_used;
	logic           scan_last;
	logic [16:0]    duty_rd;
	logic [48:0]    prod;
	logic [13:0]    presc_new;
	logic [31:0]    q_per;
	logic [16:0]    duty_sat;
	logic           out_free;

	ptsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign used16    = {12'b0, mask_q} & CH_LIM[15:0];
	assign idx       = ch_in_q[CHW-1:0];
	assign ch_ok     = used16[ch_in_q];
	assign scan_used = used16[4'(scan_q)];
	assign scan_last = ((used16 >> 4'(scan_q)) >> 1) == 16'd0;
	assign rd_idx    = (state_q == ST_SCAN) ? scan_q : idx;
	assign duty_rd   = duty_q[rd_idx];
	assign prod      = {17'b0, period_q} * {32'b0, duty_rd};
	assign out_free  = !out_valid_q || m_tready;
	assign q_per     = div_rsp.quotient[31:0];
	assign duty_sat  = (div_rsp.quotient > {31'b0, DUTY_ONE}) ? DUTY_ONE
	                                                          : div_rsp.quotient[16:0];

	always_comb begin
		if (f_in_q < FREQ_LOW) begin
			presc_new = PRESC_LOW;
		end else if (f_in_q < FREQ_MID) begin
			presc_new = PRESC_MID;
		end else begin
			presc_new = '0;
		end
	end

	always_comb begin
		act = ACT_ERR;
		case (cmd_in_q)
			CMD_ENABLE, CMD_DISABLE, CMD_GET_FREQ: act = ACT_EMIT;
			CMD_GET_DUTY, CMD_GET_RAW: act = ch_ok ? ACT_EMIT : ACT_ERR;
			CMD_SET_DUTY: act = (ch_ok && duty_in_q <= DUTY_ONE) ? ACT_MUL : ACT_ERR;
			CMD_SET_RAW: act = (ch_ok && period_q != 32'd0) ? ACT_RAW : ACT_ERR;
			CMD_SET_FREQ, CMD_SET_FREQ_DUTY: begin
				if (ch_ok && f_in_q != 32'd0
				    && (cmd_in_q != CMD_SET_FREQ_DUTY || duty_in_q <= DUTY_ONE)) begin
					act = ACT_FREQ;
				end
			end
			default: act = ACT_ERR;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_EXEC;
			ST_EXEC: begin
				case (act)
					ACT_MUL:  state_d = ST_SCAN;
					ACT_RAW:  state_d = ST_WAIT_RAW;
					ACT_FREQ: state_d = ST_WAIT_PRE;
					default:  state_d = ST_EMIT;
				endcase
			end
			ST_WAIT_PRE: if (!div_rsp.busy) state_d = ST_WAIT_PER;
			ST_WAIT_PER: if (!div_rsp.busy) state_d = ST_SCAN;
			ST_WAIT_RAW: if (!div_rsp.busy) state_d = ST_EMIT;
			ST_SCAN: if (scan_used) state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = (loop_q && !res_last_q) ? ST_SCAN : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready         = (state_q == ST_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = {2'b0, clk_hz_q, 16'b0};
		div_req.divisor  = {18'b0, presc_new} + 32'd1;
		div_req.steps    = STEPS_32;
		case (state_q)
			ST_EXEC: begin
				if (act == ACT_FREQ) begin
					div_req.start = 1'b1;
				end else if (act == ACT_RAW) begin
					div_req.start    = 1'b1;
					div_req.dividend = {raw_in_q, 16'b0};
					div_req.divisor  = period_q;
					div_req.steps    = STEPS_48;
				end
			end
			ST_WAIT_PRE: begin
				div_req.start    = !div_rsp.busy;
				div_req.dividend = {div_rsp.quotient[31:0], 16'b0};
				div_req.divisor  = f_in_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clk_hz_q    <= TIMER_CLOCK_RESET;
			mask_q      <= CHANNEL_MASK_RESET;
			presc_q     <= '0;
			period_q    <= '0;
			freq_q      <= '0;
			en_q        <= 1'b0;
			scan_q      <= '0;
			loop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				duty_q[i] <= '0;
				cmp_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_TIMER_CLOCK) begin
					clk_hz_q <= cfg_wdata;
				end else begin
					mask_q <= cfg_wdata[3:0];
				end
			end
			case (state_q)
				ST_EXEC: begin
					case (act)
						ACT_EMIT: begin
							if (cmd_in_q == CMD_ENABLE) en_q <= 1'b1;
							if (cmd_in_q == CMD_DISABLE) en_q <= 1'b0;
						end
						ACT_MUL: begin
							duty_q[idx] <= duty_in_q;
							scan_q      <= idx;
							loop_q      <= 1'b0;
						end
						ACT_FREQ: begin
							if (cmd_in_q == CMD_SET_FREQ_DUTY) duty_q[idx] <= duty_in_q;
							presc_q <= presc_new;
							freq_q  <= f_in_q;
							scan_q  <= '0;
							loop_q  <= 1'b1;
						end
						default: ;
					endcase
				end
				ST_WAIT_PER: begin
					if (!div_rsp.busy) period_q <= (q_per == 32'd0) ? 32'd0 : q_per - 32'd1;
				end
				ST_WAIT_RAW: begin
					if (!div_rsp.busy) begin
						duty_q[idx] <= duty_sat;
						cmp_q[idx]  <= raw_in_q;
					end
				end
				ST_SCAN: begin
					if (scan_used) begin
						cmp_q[scan_q] <= prod[47:16];
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free && loop_q && !res_last_q) scan_q <= scan_q + 1'b1;
				end
				default: ;
			endcase
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_in_q  <= s_tuser;
			ch_in_q   <= s_tdata[3:0];
			f_in_q    <= s_tdata[35:4];
			duty_in_q <= s_tdata[52:36];
			raw_in_q  <= s_tdata[84:53];
		end
		case (state_q)
			ST_EXEC: begin
				res_status_q <= (act == ACT_ERR);
				res_ch_q     <= '0;
				res_cmp_q    <= '0;
				res_wr_q     <= 1'b0;
				res_last_q   <= 1'b1;
				if (act == ACT_EMIT) begin
					case (cmd_in_q)
						CMD_GET_FREQ: res_read_q <= freq_q;
						CMD_GET_DUTY: res_read_q <= {15'b0, duty_rd};
						CMD_GET_RAW:  res_read_q <= cmp_q[idx];
						default:      res_read_q <= '0;
					endcase
				end else begin
					res_read_q <= '0;
				end
			end
			ST_WAIT_RAW: begin
				res_ch_q  <= ch_in_q;
				res_cmp_q <= raw_in_q;
				res_wr_q  <= 1'b1;
			end
			ST_SCAN: begin
				res_ch_q   <= 4'(scan_q);
				res_cmp_q  <= prod[47:16];
				res_wr_q   <= 1'b1;
				res_last_q <= loop_q ? scan_last : 1'b1;
			end
			ST_EMIT: begin
				if (out_free) begin
					out_data_q <= {5'b0, en_q, res_cmp_q, res_ch_q, period_q, presc_q,
					               res_read_q};
					out_user_q <= {res_wr_q, res_status_q};
					out_last_q <= res_last_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	`PTSC_ASSERT_IMP(a_ready_div_idle, s_tready, !div_rsp.busy)
	`PTSC_ASSERT_IMP(a_start_div_idle, div_req.start, !div_rsp.busy)
	`PTSC_ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready, state_q == ST_EXEC)
	`PTSC_ASSERT_NEXT(a_scan_emit, state_q == ST_SCAN && scan_used, state_q == ST_EMIT)

endmodule

@@ test/tb_pwm_timer_setting_calculator.sv @@
module tb_pwm_timer_setting_calculator;
	timeunit 1ns;
	timeprecision 1ps;

	import ptsc_pkg::*;

	localparam int NUM_CH = 4;
	localparam logic [3:0] CMD_UNKNOWN_LO = CMD_SET_FREQ_DUTY + 4'd1;
	localparam logic [3:0] CMD_UNKNOWN_HI = 4'hF;
	localparam logic [29:0] CLOCK_MAX = 30'd1000000000;

	typedef struct {
		logic        status;
		logic [31:0] read_value;
		logic [13:0] prescaler;
		logic [31:0] period;
		logic [3:0]  channel;
		logic [31:0] compare;
		logic        compare_write;
		logic        enabled;
		logic        last;
	} timer_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic [29:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [87:0]  s_tdata;  // channel, freq_hz, duty_q16, compare_raw
	logic [3:0]   s_tuser;  // command
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;  // read_value, prescaler_out, period_out, channel_out,
	                        // compare_out, enabled
	logic [1:0]   m_tuser;  // status, compare_write
	logic         m_tlast;

	// timer model
	logic [29:0] timer_clock_q;
	logic [3:0]  used_mask_q;
	logic [13:0] prescaler_q;
	logic [31:0] period_q;
	logic [31:0] freq_q;
	logic [16:0] duty_q [NUM_CH];
	logic [31:0] compare_q [NUM_CH];
	logic        enabled_q;

	timer_result_t timer_results_due[$];

	int failures = 0;
	int commands_sent = 0;
	int commands_rejected = 0;
	int results_seen = 0;
	int settings_used = 1;
	bit tx_steady = 0;
	bit rx_steady = 0;

	pwm_timer_setting_calculator #(.CHANNELS(NUM_CH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= rx_steady ? 1'b1 : ($urandom_range(0, 99) >= 21);
	end

	function automatic bit channel_in_use(input logic [3:0] ch);
		return (ch < NUM_CH) && used_mask_q[2'(ch)];
	endfunction

	function automatic logic [31:0] scaled_compare(input logic [31:0] period,
			input logic [16:0] duty);
		logic [63:0] prod;
		prod = {32'b0, period} * {47'b0, duty};
		return prod[47:16];
	endfunction

	function automatic void queue_result(input logic status, input logic [31:0] readv,
			input logic [3:0] ch, input logic [31:0] cmp, input logic wr, input logic last);
		timer_result_t r;
		r.status = status;
		r.read_value = readv;
		r.prescaler = prescaler_q;
		r.period = period_q;
		r.channel = ch;
		r.compare = cmp;
		r.compare_write = wr;
		r.enabled = enabled_q;
		r.last = last;
		timer_results_due.push_back(r);
	endfunction

	function automatic void apply_command(input logic [3:0] cmd, input logic [3:0] ch,
			input logic [31:0] f, input logic [16:0] duty, input logic [31:0] raw);
		bit rejected;
		logic [1:0] idx;
		int last_used;
		logic [31:0] base;
		logic [31:0] quot;
		logic [47:0] ratio;
		rejected = 0;
		idx = 2'(ch % NUM_CH);
		case (cmd)
			CMD_ENABLE: begin
				enabled_q = 1'b1;
				queue_result(1'b0, '0, '0, '0, 1'b0, 1'b1);
			end
			CMD_DISABLE: begin
				enabled_q = 1'b0;
				queue_result(1'b0, '0, '0, '0, 1'b0, 1'b1);
			end
			CMD_GET_FREQ: queue_result(1'b0, freq_q, '0, '0, 1'b0, 1'b1);
			CMD_SET_FREQ, CMD_SET_FREQ_DUTY: begin
				if (!channel_in_use(ch) || f == 0 ||
						(cmd == CMD_SET_FREQ_DUTY && duty > DUTY_ONE)) begin
					rejected = 1;
				end else begin
					if (cmd == CMD_SET_FREQ_DUTY)
						duty_q[idx] = duty;
					if (f < FREQ_LOW)
						prescaler_q = PRESC_LOW;
					else if (f < FREQ_MID)
						prescaler_q = PRESC_MID;
					else
						prescaler_q = '0;
					base = {2'b0, timer_clock_q} / ({18'b0, prescaler_q} + 32'd1);
					quot = base / f;
					period_q = (quot == 0) ? '0 : quot - 32'd1;
					freq_q = f;
					last_used = -1;
					for (int i = 0; i < NUM_CH; i++)
						if (channel_in_use(4'(i)))
							last_used = i;
					for (int i = 0; i < NUM_CH; i++) begin
						if (channel_in_use(4'(i))) begin
							compare_q[2'(i)] = scaled_compare(period_q, duty_q[2'(i)]);
							queue_result(1'b0, '0, 4'(i), compare_q[2'(i)], 1'b1,
								i == last_used);
						end
					end
				end
			end
			CMD_GET_DUTY: begin
				if (!channel_in_use(ch))
					rejected = 1;
				else
					queue_result(1'b0, 32'(duty_q[idx]), '0, '0, 1'b0, 1'b1);
			end
			CMD_SET_DUTY: begin
				if (!channel_in_use(ch) || duty > DUTY_ONE) begin
					rejected = 1;
				end else begin
					duty_q[idx] = duty;
					compare_q[idx] = scaled_compare(period_q, duty);
					queue_result(1'b0, '0, ch, compare_q[idx], 1'b1, 1'b1);
				end
			end
			CMD_GET_RAW: begin
				if (!channel_in_use(ch))
					rejected = 1;
				else
					queue_result(1'b0, compare_q[idx], '0, '0, 1'b0, 1'b1);
			end
			CMD_SET_RAW: begin
				if (!channel_in_use(ch) || period_q == 0) begin
					rejected = 1;
				end else begin
					ratio = {raw, 16'b0} / {16'b0, period_q};
					duty_q[idx] = (ratio > DUTY_ONE) ? DUTY_ONE : ratio[16:0];
					compare_q[idx] = raw;
					queue_result(1'b0, '0, ch, raw, 1'b1, 1'b1);
				end
			end
			default: rejected = 1;
		endcase
		if (rejected) begin
			commands_rejected++;
			queue_result(1'b1, '0, '0, '0, 1'b0, 1'b1);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		timer_result_t got;
		timer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got.read_value = m_tdata[31:0];
			got.prescaler = m_tdata[45:32];
			got.period = m_tdata[77:46];
			got.channel = m_tdata[81:78];
			got.compare = m_tdata[113:82];
			got.enabled = m_tdata[114];
			got.status = m_tuser[0];
			got.compare_write = m_tuser[1];
			got.last = m_tlast;
			if (timer_results_due.size() == 0) begin
				failures++;
				$display("%0t: unexpected result, expected none, got compare %0h channel %0d",
					$time, got.compare, got.channel);
			end else begin
				want = timer_results_due.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("read_value", want.read_value, got.read_value);
				check_field("prescaler", 32'(want.prescaler), 32'(got.prescaler));
				check_field("period", want.period, got.period);
				check_field("channel", 32'(want.channel), 32'(got.channel));
				check_field("compare", want.compare, got.compare);
				check_field("compare_write", 32'(want.compare_write), 32'(got.compare_write));
				check_field("enabled", 32'(want.enabled), 32'(got.enabled));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	task automatic send_command(input logic [3:0] cmd, input logic [3:0] ch,
			input logic [31:0] f, input logic [16:0] duty, input logic [31:0] raw);
		while (!tx_steady && $urandom_range(0, 99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b0, raw, duty, f, ch};
		do @(posedge clk); while (!s_tready);
		apply_command(cmd, ch, f, duty, raw);
		commands_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (timer_results_due.size() != 0)
			@(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_settings(input logic [29:0] clock_hz, input logic [3:0] mask);
		cfg_we <= 1'b1;
		cfg_index <= REG_TIMER_CLOCK;
		cfg_wdata <= clock_hz;
		@(posedge clk);
		cfg_index <= REG_CHANNEL_MASK;
		cfg_wdata <= {26'b0, mask};
		@(posedge clk);
		cfg_we <= 1'b0;
		timer_clock_q = clock_hz;
		used_mask_q = mask;
		settings_used++;
	endtask

	task automatic test_reset_state();
		send_command(CMD_GET_FREQ, 4'd0, '0, '0, '0);
		send_command(CMD_GET_DUTY, 4'd0, '0, '0, '0);
		send_command(CMD_GET_RAW, 4'd3, '0, '0, '0);
		send_command(CMD_SET_RAW, 4'd0, '0, '0, 32'd1234);    // zero period
		send_command(CMD_SET_DUTY, 4'd1, '0, 17'd30000, '0);  // compare 0 with no period
		send_command(CMD_ENABLE, 4'd0, '0, '0, '0);
		send_command(CMD_DISABLE, 4'd0, '0, '0, '0);
		send_command(CMD_UNKNOWN_LO, 4'd0, '0, '0, '0);
		send_command(CMD_UNKNOWN_HI, 4'd2, '1, '1, '1);
	endtask

	task automatic test_prescaler_bands();
		send_command(CMD_SET_FREQ, 4'd0, 32'd599, '0, '0);
		send_command(CMD_SET_FREQ_DUTY, 4'd2, 32'd600, DUTY_ONE, '0);
		send_command(CMD_SET_FREQ, 4'd1, 32'd1099, '0, '0);
		send_command(CMD_SET_FREQ_DUTY, 4'd3, 32'd1100, 17'd32768, '0);
		send_command(CMD_SET_FREQ, 4'd0, 32'hFFFF_FFFF, '0, '0);  // period clamps to zero
		send_command(CMD_SET_FREQ, 4'd0, 32'd1, '0, '0);
	endtask

	task automatic test_rejections();
		send_command(CMD_SET_FREQ, 4'd4, 32'd1000, '0, '0);
		send_command(CMD_SET_FREQ, 4'd1, 32'd0, '0, '0);
		send_command(CMD_SET_FREQ_DUTY, 4'd1, 32'd5000, DUTY_ONE + 17'd1, '0);
		send_command(CMD_SET_DUTY, 4'd2, '0, 17'h1FFFF, '0);
		send_command(CMD_GET_DUTY, 4'd15, '0, '0, '0);
		send_command(CMD_SET_RAW, 4'd1, '0, '0, 32'hFFFF_FFFF);  // duty clamps to 1.0
		send_command(CMD_SET_RAW, 4'd2, '0, '0, 32'd0);
		send_command(CMD_GET_DUTY, 4'd1, '0, '0, '0);
	endtask

	function automatic logic [31:0] random_freq();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(597, 603);
			2: return $urandom_range(1097, 1103);
			3: return $urandom_range(1, 599);
			4: return $urandom_range(600, 1099);
			5, 6: return $urandom_range(1100, 200000);
			7: return $urandom;
			8: return $urandom_range(200000, 40000000);
			default: return $urandom_range(1, 20);
		endcase
	endfunction

	function automatic logic [16:0] random_duty();
		case ($urandom_range(0, 19))
			0, 1: return DUTY_ONE;
			2, 3: return 17'($urandom_range(DUTY_ONE + 1, 17'h1FFFF));
			4: return '0;
			default: return 17'($urandom_range(0, DUTY_ONE));
		endcase
	endfunction

	function automatic logic [31:0] random_raw();
		case ($urandom_range(0, 4))
			0, 1: return $urandom_range(0, period_q);
			2: return (period_q > 32'h7FFF_0000) ? $urandom : period_q + $urandom_range(0, period_q);
			3: return $urandom;
			default: return $urandom_range(0, 70000);
		endcase
	endfunction

	task automatic send_random_command();
		logic [3:0] cmd;
		logic [3:0] ch;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			cmd = CMD_ENABLE;
		else if (pick < 8)
			cmd = CMD_DISABLE;
		else if (pick < 13)
			cmd = CMD_GET_FREQ;
		else if (pick < 32)
			cmd = CMD_SET_FREQ;
		else if (pick < 40)
			cmd = CMD_GET_DUTY;
		else if (pick < 59)
			cmd = CMD_SET_DUTY;
		else if (pick < 67)
			cmd = CMD_GET_RAW;
		else if (pick < 82)
			cmd = CMD_SET_RAW;
		else if (pick < 97)
			cmd = CMD_SET_FREQ_DUTY;
		else
			cmd = 4'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
		ch = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, NUM_CH - 1))
			: 4'($urandom_range(NUM_CH, 15));
		send_command(cmd, ch, random_freq(), random_duty(), random_raw());
	endtask

	task automatic test_random_phase(input logic [29:0] clock_hz, input logic [3:0] mask,
			input int count, input bit steady);
		drain_results();
		write_settings(clock_hz, mask);
		tx_steady = steady;
		rx_steady = steady;
		repeat (count)
			send_random_command();
		tx_steady = 0;
		rx_steady = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_TIMER_CLOCK;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_ENABLE;
		m_tready <= 1'b0;
		timer_clock_q = TIMER_CLOCK_RESET;
		used_mask_q = CHANNEL_MASK_RESET;
		prescaler_q = '0;
		period_q = '0;
		freq_q = '0;
		enabled_q = 1'b0;
		for (int i = 0; i < NUM_CH; i++) begin
			duty_q[2'(i)] = '0;
			compare_q[2'(i)] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_prescaler_bands();
		test_rejections();
		test_random_phase(TIMER_CLOCK_RESET, 4'hF, 40, 1'b1);
		test_random_phase(CLOCK_MAX, 4'hF, 35, 1'b0);
		test_random_phase(30'd1, 4'hF, 25, 1'b0);
		test_random_phase(TIMER_CLOCK_RESET, 4'h0, 20, 1'b0);
		test_random_phase(30'd16000000, 4'b1010, 35, 1'b0);
		test_random_phase(30'd48000000, 4'b1000, 30, 1'b0);
		test_random_phase(30'($urandom_range(1, CLOCK_MAX)), 4'($urandom_range(0, 15)),
			35, 1'b0);
		test_random_phase(30'($urandom_range(1, CLOCK_MAX)), 4'hF, 35, 1'b0);

		drain_results();
		repeat (100) @(posedge clk);
		$display("Covered %0d commands (%0d rejected) giving %0d results over %0d timer settings.",
			commands_sent, commands_rejected, results_seen, settings_used);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ pwm_timer_setting_calculator.f @@
+incdir+src
src/ptsc_pkg.sv
src/ptsc_div.sv
src/pwm_timer_setting_calculator.sv
test/tb_pwm_timer_setting_calculator.sv
